// ===== rtl/type_descriptor_checker_assert.svh =====
// Assertion macros shared by the checker's modules.
// Both sample on the rising edge of aclk and are quiet while aresetn is low.
`ifndef TYPE_DESCRIPTOR_CHECKER_ASSERT_SVH
`define TYPE_DESCRIPTOR_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tdc_pkg.sv =====
`timescale 1ns / 1ps

package tdc_pkg;

    localparam int MAX_LENGTH   = 65535;
    localparam int MAX_DEPTH    = 255;
    localparam int BYTE_COUNT_W = 17;
    localparam int BRACKET_W    = 9;
    localparam int CP_W         = 21;

    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_L       = 8'h4c;
    localparam logic [7:0] CH_V       = 8'h56;

    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_LENGTH    = 3'd1,
        RC_PRIMITIVE = 3'd2,
        RC_FORM      = 3'd3,
        RC_SEGMENT   = 3'd4,
        RC_ENCODING  = 3'd5,
        RC_TRUNCATED = 3'd6,
        RC_CHARACTER = 3'd7
    } result_code_t;

    typedef enum logic [1:0] {
        LK_CLASS     = 2'd0,
        LK_PRIMITIVE = 2'd1,
        LK_VOID      = 2'd2
    } leaf_kind_t;

    // Control from the leaf tracker to the body decoder.
    typedef struct packed {
        logic       feed;
        logic       clear;
        logic [7:0] data;
    } dec_ctrl_t;

    // Decoder status after the current byte has been taken into account.
    typedef struct packed {
        result_code_t fault;
        logic         pending;
    } dec_stat_t;

endpackage

// ===== rtl/type_descriptor_checker.sv =====
`timescale 1ns / 1ps

// Type descriptor checker. Takes a descriptor one byte per item on the s_
// channel, with s_tlast on the final byte, and returns one verdict item on the
// m_ channel per descriptor. A byte is accepted in every cycle while the
// result side keeps up. An accepted byte is loaded into the input register;
// for the final byte, the single-pass state update then loads the result
// register that drives the m_ channel, and a held result can keep the final
// byte waiting in the input register. A held result stalls only final bytes,
// so bytes in the middle of the next descriptor keep flowing.
module type_descriptor_checker #(
    parameter int MAX_LENGTH = tdc_pkg::MAX_LENGTH,
    parameter int MAX_DEPTH  = tdc_pkg::MAX_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] descriptor_byte
    input  logic        s_tlast,   // end_of_descriptor
    input  logic        s_tuser,   // [0] void_allowed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] result_code, [10:3] array_depth,
                                   // [12:11] leaf_kind, [20:13] primitive_letter
);
    import tdc_pkg::*;

    logic                    s1_valid_reg;
    logic [7:0]              s1_byte_reg;
    logic                    s1_last_reg;
    logic                    s1_void_reg;
    logic                    s1_fire;
    logic                    out_free;

    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BRACKET_W-1:0]    bracket_reg, bracket_next;
    logic                    in_leaf_reg, in_leaf_next;
    logic [1:0]              leaf_len_reg, leaf_len_next;
    logic [7:0]              leaf_first_reg, leaf_first_next;
    logic [7:0]              prev_reg, prev_next;
    logic                    slash_reg, slash_next;

    logic                    m_tvalid_reg;
    logic [23:0]             m_tdata_reg;

    logic [1:0]              k;
    logic                    is_bracket;
    logic [BYTE_COUNT_W:0]   len;
    result_code_t            code;
    leaf_kind_t              kind;
    logic [7:0]              depth;
    logic [7:0]              letter;
    dec_ctrl_t               dec_ctrl;
    dec_stat_t               dec_stat;

    function automatic logic is_primitive(input logic [7:0] c);
        return c == 8'h5a || c == 8'h42 || c == 8'h43 || c == 8'h53 ||
               c == 8'h49 || c == 8'h4a || c == 8'h46 || c == 8'h44;
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
            s1_void_reg <= s_tuser;
        end
    end

    always_comb begin
        k          = in_leaf_reg ? leaf_len_reg : 2'd0;
        is_bracket = !in_leaf_reg && s1_byte_reg == CH_BRACKET;

        byte_count_next = (&byte_count_reg) ? byte_count_reg : byte_count_reg + 1'b1;
        bracket_next    = (is_bracket && !(&bracket_reg)) ? bracket_reg + 1'b1 : bracket_reg;
        in_leaf_next    = in_leaf_reg | !is_bracket;
        leaf_first_next = (!is_bracket && k == 2'd0) ? s1_byte_reg : leaf_first_reg;
        leaf_len_next   = is_bracket ? leaf_len_reg : (k == 2'd3 ? 2'd3 : k + 2'd1);
        prev_next       = is_bracket ? prev_reg : s1_byte_reg;
        // A slash right after the L or right after another slash opens an
        // empty path segment.
        slash_next      = slash_reg | (!is_bracket && s1_byte_reg == CH_SLASH &&
                          (k == 2'd1 || (k >= 2'd2 && prev_reg == CH_SLASH)));

        // The body trails one byte behind, so the final ';' is never decoded.
        dec_ctrl.feed  = s1_fire && !is_bracket && k >= 2'd2;
        dec_ctrl.clear = s1_fire && s1_last_reg;
        dec_ctrl.data  = prev_reg;

        len = {1'b0, byte_count_reg} + 1'b1;
        if (len > (BYTE_COUNT_W+1)'(MAX_LENGTH) || bracket_next > BRACKET_W'(MAX_DEPTH) ||
            !in_leaf_next) begin
            code = RC_LENGTH;
        end else if (leaf_len_next == 2'd1) begin
            code = (is_primitive(leaf_first_next) ||
                    (leaf_first_next == CH_V && bracket_next == '0 && s1_void_reg))
                   ? RC_OK : RC_PRIMITIVE;
        end else if (leaf_first_next != CH_L || s1_byte_reg != CH_SEMI ||
                     leaf_len_next != 2'd3) begin
            code = RC_FORM;
        end else if (slash_next || prev_reg == CH_SLASH) begin
            code = RC_SEGMENT;
        end else if (dec_stat.fault != RC_OK) begin
            code = dec_stat.fault;
        end else if (dec_stat.pending) begin
            code = RC_TRUNCATED;
        end else begin
            code = RC_OK;
        end

        depth = bracket_next[BRACKET_W-1] ? 8'hff : bracket_next[7:0];
        if (in_leaf_next && leaf_len_next == 2'd1) begin
            kind   = (leaf_first_next == CH_V) ? LK_VOID : LK_PRIMITIVE;
            letter = leaf_first_next;
        end else begin
            kind   = LK_CLASS;
            letter = 8'h00;
        end
    end

    tdc_utf8_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dec_ctrl),
        .stat    (dec_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || (s1_fire && s1_last_reg)) begin
            byte_count_reg <= '0;
            bracket_reg    <= '0;
            in_leaf_reg    <= 1'b0;
            leaf_len_reg   <= 2'd0;
            leaf_first_reg <= 8'h00;
            prev_reg       <= 8'h00;
            slash_reg      <= 1'b0;
        end else if (s1_fire) begin
            byte_count_reg <= byte_count_next;
            bracket_reg    <= bracket_next;
            in_leaf_reg    <= in_leaf_next;
            leaf_len_reg   <= leaf_len_next;
            leaf_first_reg <= leaf_first_next;
            prev_reg       <= prev_next;
            slash_reg      <= slash_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_fire && s1_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            m_tdata_reg <= {3'b000, letter, kind, depth, code};
        end
    end

`include "type_descriptor_checker_assert.svh"
    `TDC_ASSERT_NOW(a_middle_never_stalls, s1_valid_reg && !s1_last_reg, s1_fire, "non-final item held back")
    `TDC_ASSERT_NEXT(a_final_gives_result, s1_fire && s1_last_reg, m_tvalid_reg, "final item gave no result")
    `TDC_ASSERT_NEXT(a_state_cleared, s1_fire && s1_last_reg, byte_count_reg == '0 && !in_leaf_reg && bracket_reg == '0, "state not cleared after final item")
    `TDC_ASSERT_NOW(a_void_ok_depth, m_tvalid_reg && m_tdata_reg[12:11] == LK_VOID && m_tdata_reg[2:0] == RC_OK, m_tdata_reg[10:3] == 8'h00, "void accepted below an array")

endmodule

// ===== rtl/tdc_utf8_decoder.sv =====
`timescale 1ns / 1ps

module tdc_utf8_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  tdc_pkg::dec_ctrl_t ctrl,
    output tdc_pkg::dec_stat_t stat
);
    import tdc_pkg::*;

    logic [CP_W-1:0] cp_reg, cp_next;
    logic [1:0]      pend_reg, pend_next;
    logic [1:0]      seq_reg, seq_next;
    result_code_t    fault_reg, fault_next;
    logic            await_reg, await_next;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] cp_shift;
    logic [7:0]      b;

    // Whitespace, controls, DEL, the Unicode spaces and the three reserved
    // punctuation marks are refused inside a class name.
    function automatic result_code_t char_class(input logic [CP_W-1:0] c);
        logic space;
        space = c == 21'h85 || c == 21'ha0 || c == 21'h1680 ||
                (c >= 21'h2000 && c <= 21'h200a) || c == 21'h2028 ||
                c == 21'h2029 || c == 21'h202f || c == 21'h205f || c == 21'h3000;
        if (c <= 21'h20 || c == 21'h7f || space || c == CP_W'(CH_SEMI) ||
            c == CP_W'(CH_BRACKET) || c == CP_W'(CH_DOT))
            return RC_CHARACTER;
        return RC_OK;
    endfunction

    assign b        = ctrl.data;
    assign pend_dec = pend_reg - 2'd1;
    assign cp_shift = {cp_reg[CP_W-7:0], b[5:0]};

    always_comb begin
        cp_next    = cp_reg;
        pend_next  = pend_reg;
        seq_next   = seq_reg;
        fault_next = fault_reg;
        await_next = await_reg;
        if (ctrl.feed) begin
            if (await_reg) begin
                // A broken sequence is only reported once its claimed length
                // has gone by, so a cut-off body still reads as truncated.
                pend_next = pend_dec;
                if (pend_dec == 2'd0) begin
                    fault_next = RC_ENCODING;
                    await_next = 1'b0;
                end
            end else if (fault_reg != RC_OK) begin
                fault_next = fault_reg;
            end else if (pend_reg == 2'd0) begin
                if (b < 8'h80) begin
                    fault_next = char_class(CP_W'(b));
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    cp_next = CP_W'(b[4:0]); pend_next = 2'd1; seq_next = 2'd1;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    cp_next = CP_W'(b[3:0]); pend_next = 2'd2; seq_next = 2'd2;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    cp_next = CP_W'(b[2:0]); pend_next = 2'd3; seq_next = 2'd3;
                end else begin
                    fault_next = RC_ENCODING;
                end
            end else begin
                pend_next = pend_dec;
                if (b[7:6] != 2'b10) begin
                    if (pend_dec == 2'd0) fault_next = RC_ENCODING;
                    else                  await_next = 1'b1;
                end else begin
                    cp_next = cp_shift;
                    if (pend_dec == 2'd0) begin
                        if ((seq_reg == 2'd1 && cp_shift < 21'h80) ||
                            (seq_reg == 2'd2 && cp_shift < 21'h800) ||
                            (seq_reg == 2'd3 && cp_shift < 21'h10000) ||
                            cp_shift > 21'h10ffff)
                            fault_next = RC_ENCODING;
                        else
                            fault_next = char_class(cp_shift);
                    end
                end
            end
        end
    end

    assign stat.fault   = fault_next;
    assign stat.pending = pend_next != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            cp_reg    <= '0;
            pend_reg  <= 2'd0;
            seq_reg   <= 2'd0;
            fault_reg <= RC_OK;
            await_reg <= 1'b0;
        end else begin
            cp_reg    <= cp_next;
            pend_reg  <= pend_next;
            seq_reg   <= seq_next;
            fault_reg <= fault_next;
            await_reg <= await_next;
        end
    end

`include "type_descriptor_checker_assert.svh"
    `TDC_ASSERT_NOW(a_pend_within_seq, 1'b1, pend_reg <= seq_reg, "pending beyond sequence length")
    `TDC_ASSERT_NOW(a_await_has_pend, await_reg, pend_reg != 2'd0, "waiting with nothing pending")
    `TDC_ASSERT_NOW(a_fault_kind, 1'b1, fault_reg == RC_OK || fault_reg == RC_ENCODING || fault_reg == RC_CHARACTER, "decoder fault of an unexpected kind")

endmodule
